/* rtl/bisection_square_root_defines.svh */
// Assertion macros shared by the bisection square root RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef BISECTION_SQUARE_ROOT_DEFINES_SVH
`define BISECTION_SQUARE_ROOT_DEFINES_SVH

// Checks an implication or property on every rising clock edge out of reset.
`define BSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds out of reset.
`define BSR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/bsr_pkg.sv */
// Constants and types of the bisection square root block.
// Used by bsr_root, bsr_cell and bisection_square_root; depends on nothing.
package bsr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_ITER   = 24;
  localparam int IN_W       = 32;
  localparam int EST_W      = 25;
  localparam int STEP_W     = 6;
  localparam int INT_W      = 9;
  localparam int LH_W       = INT_W + FRAC_BITS;
  localparam int SQ_W       = 64;
  localparam int NCELL      = MAX_ITER + 1;
  localparam int ROOT_STEPS = 8;
  localparam int ROOT_CNT_W = 3;
  localparam int SH_L       = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
  localparam int SH_R       = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;

  localparam logic [IN_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic              valid;
    logic [LH_W-1:0]   lo;
    logic [LH_W-1:0]   hi;
    logic [IN_W-1:0]   rad;
    logic [IN_W-1:0]   tol;
    logic [STEP_W-1:0] step;
  } link_t;

  typedef struct packed {
    logic              valid;
    logic [EST_W-1:0]  estimate;
    logic [STEP_W-1:0] step;
    logic              last;
    logic              conv;
  } res_t;

endpackage

/* rtl/bsr_root.sv */
// Integer bracket search: least c in 1..256 with c*c*2^16 >= radicand.
// Binary search in ROOT_STEPS steps; depends on bsr_pkg.
module bsr_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bsr_pkg::IN_W-1:0]      rad,
  output logic                          done,
  output logic [bsr_pkg::INT_W-1:0]     c_hi
);

  logic [bsr_pkg::INT_W-1:0]      lo_r, lo_nxt;
  logic [bsr_pkg::INT_W-1:0]      hi_r, hi_nxt;
  logic [bsr_pkg::ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [bsr_pkg::INT_W:0]        sum;
  logic [bsr_pkg::INT_W-1:0]      mid;
  logic [2*bsr_pkg::INT_W-1:0]    mid_sq;
  logic                           pass;

  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid    = sum[bsr_pkg::INT_W:1];
  assign mid_sq = mid * mid;
  assign pass   = {mid_sq, 16'b0} >= (2 * bsr_pkg::INT_W + 16)'(rad);

  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      lo_nxt  = '0;
      hi_nxt  = bsr_pkg::INT_W'(256);
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (pass) begin
        hi_nxt = mid;
      end else begin
        lo_nxt = mid;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bsr_pkg::ROOT_CNT_W'(bsr_pkg::ROOT_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign c_hi = hi_r;

endmodule

/* rtl/bsr_cell.sv */
// One bisection step: holds a bracket, emits its midpoint and hands the
// narrowed bracket to the next cell. Depends on bsr_pkg.
module bsr_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  bsr_pkg::link_t link_in,
  output bsr_pkg::link_t link_out,
  output bsr_pkg::res_t  result
);

  bsr_pkg::link_t                 link_r;
  logic [bsr_pkg::LH_W:0]         sum;
  logic [bsr_pkg::LH_W-1:0]       x;
  logic [2*bsr_pkg::LH_W-1:0]     sq_full;
  logic [bsr_pkg::SQ_W-1:0]       sq;
  logic [bsr_pkg::SQ_W-1:0]       v32;
  logic [bsr_pkg::SQ_W-1:0]       e32;
  logic [bsr_pkg::SQ_W-1:0]       diff;
  logic                           below;
  logic                           ok;
  logic                           cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else begin
      link_r <= link_in;
    end
  end

  assign sum     = {1'b0, link_r.lo} + {1'b0, link_r.hi};
  assign x       = sum[bsr_pkg::LH_W:1];
  assign sq_full = x * x;
  assign sq      = (bsr_pkg::SQ_W'(sq_full) << bsr_pkg::SH_L) >> bsr_pkg::SH_R;
  assign v32     = bsr_pkg::SQ_W'(link_r.rad) << 16;
  assign e32     = bsr_pkg::SQ_W'(link_r.tol) << 16;
  assign below   = sq < v32;
  assign diff    = below ? (v32 - sq) : (sq - v32);
  assign ok      = diff < e32;
  assign cap     = link_r.step >= bsr_pkg::STEP_W'(bsr_pkg::MAX_ITER);

  always_comb begin
    result.valid    = link_r.valid;
    result.estimate = bsr_pkg::EST_W'(x);
    result.step     = link_r.step;
    result.last     = ok || cap;
    result.conv     = ok;

    link_out.valid  = link_r.valid && !(ok || cap);
    link_out.lo     = below ? x : link_r.lo;
    link_out.hi     = below ? link_r.hi : x;
    link_out.rad    = link_r.rad;
    link_out.tol    = link_r.tol;
    link_out.step   = link_r.step + 1'b1;
  end

endmodule

/* rtl/bisection_square_root.sv */
// Bisection square root: once start is taken, the 8-step integer search runs,
// then the cell chain gives one estimate per cycle, up to MAX_ITER+1 words.
// A new item is taken the cycle after the last word is registered.
// Synchronous active-low reset clears the control state and the strobe.
// Depends on bsr_pkg, bsr_root, bsr_cell and the assertion header.
`include "bisection_square_root_defines.svh"

module bisection_square_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   in_radicand,
  input  logic [31:0]                   in_tolerance,
  output logic                          out_strobe,
  output logic [24:0]                   out_estimate,
  output logic [5:0]                    out_step_index,
  output logic                          out_is_last,
  output logic                          out_converged
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROOT = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bsr_pkg::IN_W-1:0]        rad_r;
  logic [bsr_pkg::IN_W-1:0]        tol_r;
  logic                            accept;
  logic                            root_done;
  logic [bsr_pkg::INT_W-1:0]       c_hi;
  bsr_pkg::link_t                  links [bsr_pkg::NCELL+1];
  bsr_pkg::res_t                   res [bsr_pkg::NCELL];
  bsr_pkg::res_t                   res_any;
  logic [bsr_pkg::NCELL-1:0]       res_valid;
  logic                            out_valid_r;
  bsr_pkg::res_t                   out_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      rad_r <= in_radicand;
      tol_r <= in_tolerance;
    end
  end

  bsr_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .rad   (rad_r),
    .done  (root_done),
    .c_hi  (c_hi)
  );

  always_comb begin
    links[0].valid = (state_r == ST_ROOT) && root_done;
    links[0].rad   = rad_r;
    links[0].tol   = tol_r;
    links[0].step  = '0;
    if (rad_r <= bsr_pkg::ONE_Q16) begin
      links[0].lo = '0;
      links[0].hi = bsr_pkg::LH_W'(1) << bsr_pkg::FRAC_BITS;
    end else begin
      links[0].lo = {c_hi - 1'b1, bsr_pkg::FRAC_BITS'(0)};
      links[0].hi = {c_hi, bsr_pkg::FRAC_BITS'(0)};
    end
  end

  for (genvar i = 0; i < bsr_pkg::NCELL; i++) begin : g_chain
    bsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .result   (res[i])
    );
    assign res_valid[i] = res[i].valid;
  end

  always_comb begin
    res_any = '0;
    for (int i = 0; i < bsr_pkg::NCELL; i++) begin
      if (res[i].valid) begin
        res_any = bsr_pkg::res_t'(res_any | res[i]);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_ROOT;
      ST_ROOT: if (root_done) state_nxt = ST_RUN;
      ST_RUN:  if (res_any.valid && res_any.last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_any.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_any;
  end

  assign out_strobe     = out_valid_r;
  assign out_estimate   = out_r.estimate;
  assign out_step_index = out_r.step;
  assign out_is_last    = out_r.last;
  assign out_converged  = out_r.conv;

  `BSR_NEVER(a_tail_empty, links[bsr_pkg::NCELL].valid, "word ran past the last cell")
  `BSR_ASSERT(a_one_word, $onehot0(res_valid), "more than one cell holds a word")
  `BSR_ASSERT(a_strobe_busy, out_strobe |-> $past(busy), "word emitted while idle")
  `BSR_ASSERT(a_cap_last, out_strobe && out_step_index >= 6'(bsr_pkg::MAX_ITER) |-> out_is_last,
              "step cap reached without a last word")

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the bisection square root block.
// Predicts every estimate word of each radicand and compares it with the strobed outputs.
// Depends on bsr_pkg and the bisection_square_root top level.
module testbench;
  import bsr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 410;

  typedef struct {
    logic [EST_W-1:0]  estimate;
    logic [STEP_W-1:0] step;
    logic              last;
    logic              conv;
  } estimate_word_t;

  class root_scoreboard;
    estimate_word_t pending_estimates[$];
    int error_count = 0;
    int words_checked = 0;
    int runs_converged = 0;
    int runs_capped = 0;

    task report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
    endtask

    function int pending();
      return pending_estimates.size();
    endfunction

    function void note_radicand(input logic [31:0] rad, input logic [31:0] tol);
      logic [63:0] v32, e32, lo, hi, x, sq, diff, c;
      int k;
      bit ok, cap;
      estimate_word_t w;
      v32 = {32'b0, rad} << 16;
      e32 = {32'b0, tol} << 16;
      if (rad <= ONE_Q16) begin
        lo = 0;
        hi = 1;
      end else begin
        c = 0;
        while (c < 256 && ((c * c) << 16) < {32'b0, rad}) c++;
        hi = c;
        lo = c - 1;
      end
      lo = lo << FRAC_BITS;
      hi = hi << FRAC_BITS;
      for (k = 0; k <= MAX_ITER; k++) begin
        x = (lo + hi) >> 1;
        sq = ((x * x) << SH_L) >> SH_R;
        diff = (sq >= v32) ? sq - v32 : v32 - sq;
        ok = diff < e32;
        cap = k >= MAX_ITER;
        w.estimate = x[EST_W-1:0];
        w.step = k[STEP_W-1:0];
        w.last = ok || cap;
        w.conv = ok;
        pending_estimates.push_back(w);
        if (ok || cap) break;
        if (sq < v32) lo = x;
        else hi = x;
      end
    endfunction

    task check_estimate(input logic [EST_W-1:0] est, input logic [STEP_W-1:0] step,
                        input logic last, input logic conv);
      estimate_word_t want;
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("unexpected word estimate=%h step=%0d", est, step));
      end else begin
        want = pending_estimates.pop_front();
        words_checked++;
        if (est !== want.estimate)
          report_mismatch($sformatf("estimate %h, predicted %h (step %0d)",
                                    est, want.estimate, want.step));
        if (step !== want.step)
          report_mismatch($sformatf("step_index %0d, predicted %0d", step, want.step));
        if (last !== want.last)
          report_mismatch($sformatf("is_last %b, predicted %b (step %0d)",
                                    last, want.last, want.step));
        if (conv !== want.conv)
          report_mismatch($sformatf("converged %b, predicted %b (step %0d)",
                                    conv, want.conv, want.step));
        if (want.last && want.conv) runs_converged++;
        if (want.last && !want.conv) runs_capped++;
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_radicand = '0;
  logic [31:0] in_tolerance = '0;
  logic        busy;
  logic        out_strobe;
  logic [24:0] out_estimate;
  logic [5:0]  out_step_index;
  logic        out_is_last;
  logic        out_converged;

  root_scoreboard roots;
  int cycle_count = 0;
  int burst_left = 0;
  int words_sent = 0;

  bisection_square_root dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_radicand   (in_radicand),
    .in_tolerance  (in_tolerance),
    .out_strobe    (out_strobe),
    .out_estimate  (out_estimate),
    .out_step_index(out_step_index),
    .out_is_last   (out_is_last),
    .out_converged (out_converged)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    roots = new();
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      roots.check_estimate(out_estimate, out_step_index, out_is_last, out_converged);
  end

  task drive_word(input logic [31:0] r, input logic [31:0] t);
    int gap;
    start <= 1'b1;
    in_radicand <= r;
    in_tolerance <= t;
    do @(posedge clk); while (busy);
    roots.note_radicand(r, t);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_radicand();
    logic [63:0] base;
    logic [63:0] c;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32'h0002_0000);
      1: begin
        c = $urandom_range(1, 256);
        base = ((c * c) << 16) + $urandom_range(0, 4);
        base = (base >= 2) ? base - 2 : base;
        return (base > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : base[31:0];
      end
      2: return $urandom >> $urandom_range(0, 31);
      3: return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_tolerance();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return $urandom_range(0, 15);
      2: return $urandom >> $urandom_range(8, 31);
      3: return $urandom_range(1, 32'h100);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_word(32'h0000_0000, 32'h0000_0000);
    drive_word(32'h0000_0000, 32'hFFFF_FFFF);
    drive_word(32'h0000_0001, 32'h0000_0000);
    drive_word(32'h0001_0000, 32'h0000_0000);
    drive_word(32'h0001_0000, 32'h0001_0000);
    drive_word(32'h0001_0001, 32'h0000_0100);
    drive_word(32'h0000_FFFF, 32'h7FFF_FFFF);
    drive_word(32'h0002_0000, 32'h0000_0000);
    drive_word(32'h0002_0000, 32'h0000_1000);
    drive_word(32'h0004_0000, 32'h0000_0010);
    drive_word(32'h0004_0001, 32'h0000_0000);
    drive_word(32'h0009_0000, 32'h0000_0001);
    drive_word(32'h00C8_0000, 32'h0000_0001);
    drive_word(32'h1234_5678, 32'h0000_FFFF);
    drive_word(32'h8000_0000, 32'h8000_0000);
    drive_word(32'hFFFF_0000, 32'h0000_8000);
    drive_word(32'hFFFF_FFFF, 32'h0000_0000);
    drive_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_word(32'hFE01_0000, 32'h0000_0002);
    drive_word(32'hAAAA_AAAA, 32'h5555_5555);

    repeat (RANDOM_WORDS) drive_word(pick_radicand(), pick_tolerance());
    start <= 1'b0;

    while (roots.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d radicand words, checked %0d estimate words", words_sent,
             roots.words_checked);
    $display("%0d runs met the tolerance, %0d ran to the step cap, %0d mismatches",
             roots.runs_converged, roots.runs_capped, roots.error_count);
    if (roots.error_count == 0 && roots.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bsr_pkg.sv
rtl/bsr_root.sv
rtl/bsr_cell.sv
rtl/bisection_square_root.sv
tb/sv/testbench.sv
